[hdl/dsrp_pkg.sv]
package dsrp_pkg;

  localparam int unsigned DEF_SLOT_COUNT = 4;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned LINK_W = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [LINK_W-1:0] MIN_LINKS = 3'd2;
  localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd10000;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_AUTO  = 2'd1,
    MODE_SMART = 2'd2
  } rotate_mode_e;

  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_PEEK = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROTATE_MODE     = 1'b0,
    REG_ROTATE_INTERVAL = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]        rotate_mode;
    logic [TIME_W-1:0] rotate_interval_ms;
  } dsrp_cfg_t;

  typedef struct packed {
    logic slot_changed;
    logic wake_display;
    logic refresh_request;
    logic clear_finish_hold;
  } dsrp_flags_t;

endpackage

[hdl/dsrp_cfg.sv]
module dsrp_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dsrp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dsrp_pkg::TIME_W-1:0]        cfg_data_i,
  output dsrp_pkg::dsrp_cfg_t                cfg_o
);
  import dsrp_pkg::*;

  logic [1:0]        mode_q, mode_d;
  logic [TIME_W-1:0] interval_q, interval_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    mode_d     = mode_q;
    interval_d = interval_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ROTATE_MODE:     mode_d = cfg_data_i[1:0];
        REG_ROTATE_INTERVAL: interval_d = cfg_data_i;
        default: begin
          mode_d     = mode_q;
          interval_d = interval_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_OFF;
      interval_q <= INTERVAL_RESET;
    end else begin
      mode_q     <= mode_d;
      interval_q <= interval_d;
    end
  end

  assign cfg_o.rotate_mode        = mode_q;
  assign cfg_o.rotate_interval_ms = interval_q;

endmodule

[hdl/dsrp_core.sv]
module dsrp_core #(
  parameter int unsigned SLOT_COUNT = dsrp_pkg::DEF_SLOT_COUNT,
  localparam int unsigned SW = $clog2(SLOT_COUNT)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              advance_i,
  input  dsrp_pkg::dsrp_cfg_t               cfg_i,
  input  logic                              operation_i,
  input  logic [dsrp_pkg::TIME_W-1:0]       now_ms_i,
  input  logic [SLOT_COUNT-1:0]             configured_mask_i,
  input  logic [SLOT_COUNT-1:0]             connected_mask_i,
  input  logic [SLOT_COUNT-1:0]             active_mask_i,
  input  logic                              sleep_screen_i,
  input  logic [dsrp_pkg::LINK_W-1:0]       link_count_i,
  output logic [SW-1:0]                     shown_slot_o,
  output dsrp_pkg::dsrp_flags_t             flags_o
);
  import dsrp_pkg::*;

  logic [SW-1:0]         shown_q, shown_d;
  logic [TIME_W-1:0]     last_q, last_d;
  logic [TIME_W-1:0]     hold_q, hold_d;

  logic [SLOT_COUNT-1:0] cfg_m, con_m, act_m, step_mask;
  logic [SW:0]           cand;
  logic [SW-1:0]         step_idx, low_idx;
  logic                  step_found;
  logic                  smart_path, act_single, act_has_shown;
  logic [TIME_W-1:0]     hold_diff, elapsed;
  logic                  hold_open, elapsed_ok, rot_en;

  assign cfg_m = configured_mask_i;
  assign con_m = connected_mask_i & cfg_m;
  assign act_m = active_mask_i & cfg_m;

  assign smart_path    = (cfg_i.rotate_mode == MODE_SMART) && (act_m != '0);
  assign act_single    = (act_m != '0) && ((act_m & (act_m - SLOT_COUNT'(1))) == '0);
  assign act_has_shown = act_m[shown_q];

  assign hold_diff  = hold_q - now_ms_i;
  assign hold_open  = (hold_q != '0) && (hold_diff != '0) && !hold_diff[TIME_W-1];
  assign elapsed    = now_ms_i - last_q;
  assign elapsed_ok = elapsed >= cfg_i.rotate_interval_ms;
  assign rot_en     = (cfg_i.rotate_mode != MODE_OFF) && (link_count_i >= MIN_LINKS);

  always_comb begin
    if (operation_i == OP_PEEK) begin
      step_mask = cfg_m;
    end else if (smart_path) begin
      step_mask = act_m;
    end else begin
      step_mask = con_m;
    end
  end

  always_comb begin
    step_found = 1'b0;
    step_idx   = shown_q;
    cand       = '0;
    for (int a = SLOT_COUNT - 1; a >= 1; a--) begin
      cand = {1'b0, shown_q} + (SW+1)'(a);
      if (cand >= (SW+1)'(SLOT_COUNT)) begin
        cand = cand - (SW+1)'(SLOT_COUNT);
      end
      if (step_mask[cand[SW-1:0]]) begin
        step_found = 1'b1;
        step_idx   = cand[SW-1:0];
      end
    end
  end

  always_comb begin
    low_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (act_m[i]) begin
        low_idx = SW'(i);
      end
    end
  end

  always_comb begin
    shown_d = shown_q;
    last_d  = last_q;
    hold_d  = hold_q;
    flags_o = '0;
    if (operation_i == OP_PEEK) begin
      if (step_found) begin
        shown_d                   = step_idx;
        last_d                    = now_ms_i;
        hold_d                    = now_ms_i + cfg_i.rotate_interval_ms;
        flags_o.refresh_request   = 1'b1;
        flags_o.clear_finish_hold = 1'b1;
      end
    end else if (rot_en && !(sleep_screen_i && (act_m == '0))) begin
      flags_o.wake_display = sleep_screen_i;
      if (!hold_open) begin
        if (smart_path) begin
          if (act_single || !act_has_shown) begin
            shown_d = low_idx;
            last_d  = now_ms_i;
          end else if (elapsed_ok) begin
            if (step_found) begin
              shown_d = step_idx;
            end
            last_d = now_ms_i;
          end
        end else if ((con_m != '0) && elapsed_ok) begin
          if (step_found) begin
            shown_d = step_idx;
          end
          last_d = now_ms_i;
        end
      end
    end
    flags_o.slot_changed = (shown_d != shown_q);
  end

  assign shown_slot_o = shown_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_q <= '0;
      last_q  <= '0;
      hold_q  <= '0;
    end else if (advance_i) begin
      shown_q <= shown_d;
      last_q  <= last_d;
      hold_q  <= hold_d;
    end
  end

endmodule

[hdl/display_slot_rotation_policy.sv]
// Path: an accepted input transfer is captured in the stage-1 input registers; the result
// is loaded from them into the output register when the output side is not stalled.
// Throughput: one item per cycle while the output is not stalled; the slot state
// register is updated together with the result register, so the next item sees it at once.
// Reset: asynchronous, active low; clears valid flags and slot state, sets mode to off
// and the interval to 10000 ms. The block accepts items as soon as reset is released.
module display_slot_rotation_policy #(
  parameter int unsigned SLOT_COUNT = dsrp_pkg::DEF_SLOT_COUNT,
  localparam int unsigned SW = $clog2(SLOT_COUNT)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dsrp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dsrp_pkg::TIME_W-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            operation_i,
  input  logic [dsrp_pkg::TIME_W-1:0]     now_ms_i,
  input  logic [SLOT_COUNT-1:0]           configured_mask_i,
  input  logic [SLOT_COUNT-1:0]           connected_mask_i,
  input  logic [SLOT_COUNT-1:0]           active_mask_i,
  input  logic                            sleep_screen_i,
  input  logic [dsrp_pkg::LINK_W-1:0]     link_count_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [SW-1:0]                   shown_slot_o,
  output logic                            slot_changed_o,
  output logic                            wake_display_o,
  output logic                            refresh_request_o,
  output logic                            clear_finish_hold_o
);
  import dsrp_pkg::*;

  dsrp_cfg_t             cfg;
  logic                  s1_valid_q, s1_valid_d;
  logic                  op_q;
  logic [TIME_W-1:0]     now_q;
  logic [SLOT_COUNT-1:0] conf_q, conn_q, act_q;
  logic                  sleep_q;
  logic [LINK_W-1:0]     links_q;
  logic                  load, advance;
  logic                  out_valid_q, out_valid_d;
  logic [SW-1:0]         shown_slot_q, shown_next;
  dsrp_flags_t           flags_q, flags_next;

  dsrp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d  = load ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
    out_valid_d = advance ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q    <= operation_i;
      now_q   <= now_ms_i;
      conf_q  <= configured_mask_i;
      conn_q  <= connected_mask_i;
      act_q   <= active_mask_i;
      sleep_q <= sleep_screen_i;
      links_q <= link_count_i;
    end
    if (advance) begin
      shown_slot_q <= shown_next;
      flags_q      <= flags_next;
    end
  end

  dsrp_core #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .advance_i         (advance),
    .cfg_i             (cfg),
    .operation_i       (op_q),
    .now_ms_i          (now_q),
    .configured_mask_i (conf_q),
    .connected_mask_i  (conn_q),
    .active_mask_i     (act_q),
    .sleep_screen_i    (sleep_q),
    .link_count_i      (links_q),
    .shown_slot_o      (shown_next),
    .flags_o           (flags_next)
  );

  assign out_valid_o         = out_valid_q;
  assign shown_slot_o        = shown_slot_q;
  assign slot_changed_o      = flags_q.slot_changed;
  assign wake_display_o      = flags_q.wake_display;
  assign refresh_request_o   = flags_q.refresh_request;
  assign clear_finish_hold_o = flags_q.clear_finish_hold;

endmodule

[hdl/dsrp_checker.sv]
module dsrp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic slot_changed_o,
  input logic wake_display_o,
  input logic refresh_request_o,
  input logic clear_finish_hold_o
);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result dropped while the output was stalled.");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled although the output side can take a transfer.");

  a_peek_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && refresh_request_o |-> slot_changed_o && clear_finish_hold_o)
    else $error("Peek result flags are inconsistent.");

  a_wake_not_peek: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(wake_display_o && (refresh_request_o || clear_finish_hold_o)))
    else $error("Wake request reported together with peek flags.");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("Handshake outputs active after a reset cycle.");

endmodule

bind display_slot_rotation_policy dsrp_checker u_dsrp_checker (.*);

[verif/tb_display_slot_rotation_policy.sv]
`timescale 1ns / 1ps

module tb_display_slot_rotation_policy;
  import dsrp_pkg::*;

  localparam logic [1:0] MODE_AUTO_ALT = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 200;

  typedef struct packed {
    logic [1:0] slot;
    logic       changed;
    logic       wake;
    logic       refresh;
    logic       clear_hold;
  } slot_view_t;

  typedef struct {
    op_e         op;
    logic [31:0] now;
    logic [3:0]  cfg_mask;
    logic [3:0]  con_mask;
    logic [3:0]  act_mask;
    logic        sleep;
    logic [2:0]  links;
  } policy_item_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_REG
  } row_kind_e;

  typedef struct {
    row_kind_e    kind;
    policy_item_t it;
    logic         typed;
    slot_view_t   want;
    reg_idx_e     idx;
    logic [31:0]  wdata;
  } plan_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [TIME_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic operation_i = 1'b0;
  logic [TIME_W-1:0] now_ms_i = '0;
  logic [3:0] configured_mask_i = '0;
  logic [3:0] connected_mask_i = '0;
  logic [3:0] active_mask_i = '0;
  logic sleep_screen_i = 1'b0;
  logic [LINK_W-1:0] link_count_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] shown_slot_o;
  logic slot_changed_o;
  logic wake_display_o;
  logic refresh_request_o;
  logic clear_finish_hold_o;

  logic calm = 1'b0;
  int unsigned cycle_count = 0;
  int error_count = 0;
  slot_view_t pending_views[$];

  logic [1:0] mode_q = MODE_OFF;
  logic [31:0] interval_q = INTERVAL_RESET;
  logic [1:0] shown_q = 2'd0;
  logic [31:0] last_rot_q = '0;
  logic [31:0] hold_end_q = '0;

  display_slot_rotation_policy DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .operation_i         (operation_i),
    .now_ms_i            (now_ms_i),
    .configured_mask_i   (configured_mask_i),
    .connected_mask_i    (connected_mask_i),
    .active_mask_i       (active_mask_i),
    .sleep_screen_i      (sleep_screen_i),
    .link_count_i        (link_count_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .shown_slot_o        (shown_slot_o),
    .slot_changed_o      (slot_changed_o),
    .wake_display_o      (wake_display_o),
    .refresh_request_o   (refresh_request_o),
    .clear_finish_hold_o (clear_finish_hold_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [2:0] seek_after(logic [3:0] mask, logic [1:0] start_slot);
    logic [1:0] cand;
    for (int a = 1; a < 4; a++) begin
      cand = start_slot + a[1:0];
      if (mask[cand]) return {1'b1, cand};
    end
    return {1'b0, start_slot};
  endfunction

  function automatic logic [1:0] lowest_set(logic [3:0] mask);
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) return i[1:0];
    end
    return 2'd0;
  endfunction

  function automatic slot_view_t predict_slot_view(policy_item_t it);
    logic [3:0] cfg_m;
    logic [3:0] con_m;
    logic [3:0] act_m;
    logic [1:0] prior;
    logic [2:0] hop;
    logic [31:0] left;
    logic proceed;
    slot_view_t v;
    cfg_m = it.cfg_mask;
    con_m = it.con_mask & cfg_m;
    act_m = it.act_mask & cfg_m;
    prior = shown_q;
    v = '0;
    if (it.op == OP_PEEK) begin
      hop = seek_after(cfg_m, shown_q);
      if (hop[2]) begin
        shown_q = hop[1:0];
        last_rot_q = it.now;
        hold_end_q = it.now + interval_q;
        v.refresh = 1'b1;
        v.clear_hold = 1'b1;
      end
    end else if (mode_q != MODE_OFF && it.links >= MIN_LINKS) begin
      proceed = 1'b1;
      if (it.sleep) begin
        if (act_m == 4'd0) proceed = 1'b0;
        else v.wake = 1'b1;
      end
      if (proceed && hold_end_q != 32'd0) begin
        left = hold_end_q - it.now;
        if (left != 32'd0 && !left[31]) proceed = 1'b0;
      end
      if (proceed) begin
        if (mode_q == MODE_SMART && act_m != 4'd0) begin
          if ($countones(act_m) == 1 || !act_m[shown_q]) begin
            shown_q = lowest_set(act_m);
            last_rot_q = it.now;
          end else if (it.now - last_rot_q >= interval_q) begin
            hop = seek_after(act_m, shown_q);
            shown_q = hop[1:0];
            last_rot_q = it.now;
          end
        end else if (con_m != 4'd0 && it.now - last_rot_q >= interval_q) begin
          hop = seek_after(con_m, shown_q);
          shown_q = hop[1:0];
          last_rot_q = it.now;
        end
      end
    end
    v.slot = shown_q;
    v.changed = (shown_q != prior);
    return v;
  endfunction

  function automatic slot_view_t view(logic [1:0] slot, logic chg, logic wake, logic refr,
                                      logic clr);
    return {slot, chg, wake, refr, clr};
  endfunction

  function automatic plan_row_t row_item(op_e op, logic [31:0] now, logic [3:0] cfg,
                                         logic [3:0] con, logic [3:0] act, logic sleep,
                                         logic [2:0] links, logic typed, slot_view_t want);
    plan_row_t r;
    r.kind = ROW_ITEM;
    r.it.op = op;
    r.it.now = now;
    r.it.cfg_mask = cfg;
    r.it.con_mask = con;
    r.it.act_mask = act;
    r.it.sleep = sleep;
    r.it.links = links;
    r.typed = typed;
    r.want = want;
    r.idx = REG_ROTATE_MODE;
    r.wdata = '0;
    return r;
  endfunction

  function automatic plan_row_t row_reg(reg_idx_e idx, logic [31:0] data);
    plan_row_t r;
    r = row_item(OP_TICK, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0);
    r.kind = ROW_REG;
    r.idx = idx;
    r.wdata = data;
    return r;
  endfunction

  task automatic report_error(string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [1:0] got, logic [1:0] want);
    if (got !== want) report_error($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task automatic send_item(policy_item_t it, logic typed, slot_view_t want);
    slot_view_t predicted;
    if (!calm && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= it.op;
    now_ms_i <= it.now;
    configured_mask_i <= it.cfg_mask;
    connected_mask_i <= it.con_mask;
    active_mask_i <= it.act_mask;
    sleep_screen_i <= it.sleep;
    link_count_i <= it.links;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = predict_slot_view(it);
    pending_views.push_back(typed ? want : predicted);
  endtask

  // The block must be drained before a register transfer.
  task automatic write_reg(reg_idx_e idx, logic [31:0] data);
    in_valid_i <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_ROTATE_MODE) mode_q = data[1:0];
    else interval_q = data;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    slot_view_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_views.size() == 0) begin
        report_error("result transfer with no expectation pending");
      end else begin
        want = pending_views.pop_front();
        check_field("shown_slot", shown_slot_o, want.slot);
        check_field("slot_changed", {1'b0, slot_changed_o}, {1'b0, want.changed});
        check_field("wake_display", {1'b0, wake_display_o}, {1'b0, want.wake});
        check_field("refresh_request", {1'b0, refresh_request_o}, {1'b0, want.refresh});
        check_field("clear_finish_hold", {1'b0, clear_finish_hold_o},
                    {1'b0, want.clear_hold});
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 25);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t plan[$];
    policy_item_t it;
    logic [31:0] clock_ms;
    logic [1:0] mode_pick;
    int unsigned intv;
    int unsigned step;

    plan.push_back(row_item(OP_TICK, 32'd20000, 4'hF, 4'hF, 4'hF, 1'b0, 3'd4, 1'b1,
                            view(2'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
    plan.push_back(row_item(OP_PEEK, 32'd100, 4'hF, 4'h0, 4'h0, 1'b0, 3'd0, 1'b1,
                            view(2'd1, 1'b1, 1'b0, 1'b1, 1'b1)));
    plan.push_back(row_item(OP_PEEK, 32'd150, 4'h2, 4'hF, 4'hF, 1'b1, 3'd7, 1'b1,
                            view(2'd1, 1'b0, 1'b0, 1'b0, 1'b0)));
    plan.push_back(row_item(OP_PEEK, 32'd160, 4'h0, 4'hF, 4'hF, 1'b0, 3'd2, 1'b1,
                            view(2'd1, 1'b0, 1'b0, 1'b0, 1'b0)));
    plan.push_back(row_reg(REG_ROTATE_MODE, {30'd0, MODE_SMART}));
    plan.push_back(row_item(OP_TICK, 32'd5000, 4'hF, 4'hF, 4'h1, 1'b0, 3'd2, 1'b1,
                            view(2'd1, 1'b0, 1'b0, 1'b0, 1'b0)));
    plan.push_back(row_item(OP_TICK, 32'd10100, 4'hF, 4'hF, 4'h1, 1'b0, 3'd2, 1'b0, '0));
    plan.push_back(row_item(OP_TICK, 32'd10200, 4'hF, 4'hF, 4'h0, 1'b1, 3'd7, 1'b1,
                            view(2'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
    plan.push_back(row_item(OP_TICK, 32'd10300, 4'hF, 4'hF, 4'h6, 1'b1, 3'd5, 1'b0, '0));
    plan.push_back(row_item(OP_TICK, 32'd29000, 4'hF, 4'hF, 4'hF, 1'b0, 3'd1, 1'b1,
                            view(2'd1, 1'b0, 1'b0, 1'b0, 1'b0)));
    plan.push_back(row_item(OP_TICK, 32'd30000, 4'hF, 4'hF, 4'h6, 1'b0, 3'd3, 1'b0, '0));
    plan.push_back(row_item(OP_TICK, 32'd30001, 4'hF, 4'h9, 4'h0, 1'b0, 3'd4, 1'b0, '0));
    plan.push_back(row_item(OP_PEEK, 32'hFFFF_D8F0, 4'hF, 4'hF, 4'h0, 1'b0, 3'd4, 1'b0,
                            '0));
    plan.push_back(row_reg(REG_ROTATE_INTERVAL, 32'd0));
    plan.push_back(row_item(OP_TICK, 32'd0, 4'hF, 4'h0, 4'h0, 1'b0, 3'd2, 1'b1,
                            view(2'd3, 1'b0, 1'b0, 1'b0, 1'b0)));
    plan.push_back(row_item(OP_TICK, 32'd5, 4'hF, 4'h8, 4'h0, 1'b0, 3'd2, 1'b0, '0));
    plan.push_back(row_item(OP_TICK, 32'd6, 4'h0, 4'hF, 4'hF, 1'b1, 3'd4, 1'b1,
                            view(2'd3, 1'b0, 1'b0, 1'b0, 1'b0)));
    plan.push_back(row_reg(REG_ROTATE_MODE, {30'd0, MODE_AUTO_ALT}));
    plan.push_back(row_item(OP_TICK, 32'd6, 4'hF, 4'h5, 4'hF, 1'b0, 3'd2, 1'b0, '0));
    plan.push_back(row_item(OP_TICK, 32'd7, 4'hF, 4'hF, 4'hF, 1'b0, 3'd6, 1'b0, '0));
    plan.push_back(row_reg(REG_ROTATE_INTERVAL, 32'hFFFF_FFFF));
    plan.push_back(row_reg(REG_ROTATE_MODE, {30'd0, MODE_AUTO}));
    plan.push_back(row_item(OP_PEEK, 32'hFFFF_FFFF, 4'hF, 4'hF, 4'h0, 1'b0, 3'd2, 1'b0,
                            '0));
    plan.push_back(row_item(OP_TICK, 32'h7FFF_FFFE, 4'hF, 4'hF, 4'h0, 1'b0, 3'd2, 1'b0,
                            '0));
    plan.push_back(row_item(OP_TICK, 32'hFFFF_FFFE, 4'hF, 4'hF, 4'h0, 1'b0, 3'd4, 1'b0,
                            '0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_REG) write_reg(plan[r].idx, plan[r].wdata);
      else send_item(plan[r].it, plan[r].typed, plan[r].want);
    end

    clock_ms = $urandom;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 3) mode_pick = MODE_AUTO_ALT;
      else if (ph == 4) mode_pick = MODE_OFF;
      else if (ph % 3 == 1) mode_pick = MODE_AUTO;
      else mode_pick = MODE_SMART;
      if (ph == 0) intv = 0;
      else if (ph == 7) intv = 32'hFFFF_FFFF;
      else if (ph == 2) intv = 10000;
      else intv = $urandom_range(1, 60);
      write_reg(REG_ROTATE_MODE, {30'd0, mode_pick});
      write_reg(REG_ROTATE_INTERVAL, intv);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        calm <= (ph == 5 && k >= 30 && k < 170);
        if ($urandom_range(0, 99) < 3) begin
          clock_ms = $urandom;
        end else begin
          if (intv <= 100) step = $urandom_range(0, 2 * intv + 3);
          else step = $urandom_range(0, 20000);
          clock_ms = clock_ms + step;
        end
        it.op = ($urandom_range(0, 99) < 12) ? OP_PEEK : OP_TICK;
        it.now = clock_ms;
        it.cfg_mask = ($urandom_range(0, 9) < 7) ? 4'hF : 4'($urandom_range(0, 15));
        it.con_mask = 4'($urandom_range(0, 15));
        it.act_mask = ($urandom_range(0, 9) < 4) ? 4'h0 : 4'($urandom_range(0, 15));
        it.sleep = ($urandom_range(0, 9) < 2);
        it.links = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(2, 4))
                                                : 3'($urandom_range(0, 7));
        send_item(it, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[display_slot_rotation_policy.f]
hdl/dsrp_pkg.sv
hdl/dsrp_cfg.sv
hdl/dsrp_core.sv
hdl/display_slot_rotation_policy.sv
hdl/dsrp_checker.sv
verif/tb_display_slot_rotation_policy.sv
